### hdl/hgsp_pkg.sv
// ----------------------------------------------------------------------------
// hgsp_pkg
// Shared types, sizes and codes for the hexagonal grid shortest path engine.
// ----------------------------------------------------------------------------
package hgsp_pkg;

	localparam int GRID_W    = 16;
	localparam int GRID_H    = 16;
	localparam int CELLS     = GRID_W * GRID_H;
	localparam int GRID_MAX  = (GRID_W > GRID_H) ? GRID_W : GRID_H;
	localparam int HOP_W     = $clog2(CELLS);
	localparam int CRD_W     = 4;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int STEP_W    = 4;
	localparam int COST_W    = 12;
	localparam int STAT_W    = 2;
	localparam int PROD_W    = HOP_W + STEP_W;
	// wide enough for a clamped dimension and for the raw register value
	localparam int DIM_W     = ($clog2(GRID_MAX + 1) > CFG_W) ? $clog2(GRID_MAX + 1) : CFG_W;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	// command codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_WRITTEN = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FOUND   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_UNREACH = 2'd2;
	localparam logic [STAT_W-1:0] STAT_REJECT  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP = 2'd2;

	localparam logic [CFG_W-1:0]  COLS_RESET = 5'd16;
	localparam logic [CFG_W-1:0]  ROWS_RESET = 5'd16;
	localparam logic [STEP_W-1:0] STEP_RESET = 4'd1;

	typedef struct packed {
		logic             cmd;
		logic [CRD_W-1:0] cell_x;
		logic [CRD_W-1:0] cell_y;
		logic             cell_blocked;
		logic [CRD_W-1:0] start_x;
		logic [CRD_W-1:0] start_y;
		logic [CRD_W-1:0] target_x;
		logic [CRD_W-1:0] target_y;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [COST_W-1:0] path_cost;
	} rsp_t;

	// controls shared by every row cell
	typedef struct packed {
		logic              wr_en;
		logic [CRD_W-1:0]  wr_x;
		logic              wr_blk;
		logic              load;
		logic              step;
		logic [CRD_W-1:0]  start_x;
		logic [CRD_W-1:0]  tgt_x;
		logic [GRID_W-1:0] col_en;
	} cell_ctl_t;

	// controls that differ per row
	typedef struct packed {
		logic wr_sel;
		logic start_sel;
		logic tgt_sel;
		logic row_en;
		logic odd;
	} row_ctl_t;

	typedef struct packed {
		logic hit;
		logic any;
		logic tgt_blk;
	} row_stat_t;

	function automatic logic [GRID_W-1:0] col_onehot(input logic [CRD_W-1:0] x);
		logic [GRID_W-1:0] v;
		for (int i = 0; i < GRID_W; i++) begin
			v[i] = (32'(x) == i);
		end
		return v;
	endfunction

endpackage

### hdl/hex_grid_shortest_path.sv
// ----------------------------------------------------------------------------
// hex_grid_shortest_path
// Offset-row hex grid map with a breadth-first shortest path search.
// ----------------------------------------------------------------------------
// channel  | handshake             | word
// request  | start & !busy         | req_t: cmd, cell, start and target coordinates
// result   | done (one cycle)      | rsp_t: status, path_cost
// config   | cfg_we                | cfg_index, cfg_data
//
// A map write: its word appears on the next cycle and a new request may be taken
// at once. A search latches the request, then checks it and seeds the wavefront,
// then advances the wavefront one hop at a time through the row cells. Reset
// clears the map to all open. The receiver cannot stall; each result word is
// shown for one cycle.
// ----------------------------------------------------------------------------
module hex_grid_shortest_path
	import hgsp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 request,
	output logic                 done,
	output rsp_t                 result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam logic [1:0] FSM_IDLE   = 2'd0;
	localparam logic [1:0] FSM_CHECK  = 2'd1;
	localparam logic [1:0] FSM_SEARCH = 2'd2;

	logic [1:0]        state_q;
	logic [CFG_W-1:0]  cols_q;
	logic [CFG_W-1:0]  rows_q;
	logic [STEP_W-1:0] step_q;
	req_t              req_q;
	logic [HOP_W-1:0]  hop_q;
	logic              done_q;
	rsp_t              rsp_q;

	logic              accept;
	logic [DIM_W-1:0]  w_eff;
	logic [DIM_W-1:0]  h_eff;
	logic [HOP_W-1:0]  hop_next;
	logic [PROD_W-1:0] prod;
	logic [COST_W-1:0] cost;
	logic              reject;
	logic              any_hit;
	logic              any_new;
	logic              tgt_blk;
	cell_ctl_t         ctl;

	logic [GRID_W-1:0] frontier [GRID_H];
	row_stat_t         stat     [GRID_H];

	assign accept = start && (state_q == FSM_IDLE);
	assign busy   = (state_q != FSM_IDLE);

	// clamp the used area into the grid
	always_comb begin
		if (cols_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (32'(cols_q) > GRID_W) begin
			w_eff = DIM_W'(GRID_W);
		end else begin
			w_eff = DIM_W'(cols_q);
		end
		if (rows_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (32'(rows_q) > GRID_H) begin
			h_eff = DIM_W'(GRID_H);
		end else begin
			h_eff = DIM_W'(rows_q);
		end
	end

	always_comb begin
		ctl.wr_en   = accept && (request.cmd == CMD_WRITE) &&
			(32'(request.cell_x) < GRID_W) && (32'(request.cell_y) < GRID_H);
		ctl.wr_x    = request.cell_x;
		ctl.wr_blk  = request.cell_blocked;
		ctl.load    = (state_q == FSM_CHECK);
		ctl.step    = (state_q == FSM_SEARCH);
		ctl.start_x = req_q.start_x;
		ctl.tgt_x   = req_q.target_x;
		for (int i = 0; i < GRID_W; i++) begin
			ctl.col_en[i] = (32'(w_eff) > i);
		end
	end

	for (genvar r = 0; r < GRID_H; r++) begin : g_row
		row_ctl_t          row;
		logic [GRID_W-1:0] up;
		logic [GRID_W-1:0] dn;

		assign row.wr_sel    = (32'(request.cell_y) == r);
		assign row.start_sel = (32'(req_q.start_y) == r);
		assign row.tgt_sel   = (32'(req_q.target_y) == r);
		assign row.row_en    = (32'(h_eff) > r);
		assign row.odd       = ((r % 2) == 1);

		if (r == 0) begin : g_top
			assign up = '0;
		end else begin : g_mid
			assign up = frontier[r-1];
		end
		if (r == GRID_H - 1) begin : g_bot
			assign dn = '0;
		end else begin : g_low
			assign dn = frontier[r+1];
		end

		hgsp_row_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.row         (row),
			.up_frontier (up),
			.dn_frontier (dn),
			.frontier    (frontier[r]),
			.stat        (stat[r])
		);
	end

	always_comb begin
		any_hit = 1'b0;
		any_new = 1'b0;
		tgt_blk = 1'b0;
		for (int r = 0; r < GRID_H; r++) begin
			any_hit = any_hit | stat[r].hit;
			any_new = any_new | stat[r].any;
			tgt_blk = tgt_blk | stat[r].tgt_blk;
		end
	end

	assign reject = (DIM_W'(req_q.start_x) >= w_eff) || (DIM_W'(req_q.start_y) >= h_eff) ||
		(DIM_W'(req_q.target_x) >= w_eff) || (DIM_W'(req_q.target_y) >= h_eff) ||
		tgt_blk ||
		((req_q.start_x == req_q.target_x) && (req_q.start_y == req_q.target_y));

	assign hop_next = hop_q + HOP_W'(1);
	assign prod     = PROD_W'(hop_next) * PROD_W'(step_q);
	assign cost     = (32'(prod) > 32'(COST_MAX)) ? COST_MAX : COST_W'(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
			step_q <= STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLS: cols_q <= cfg_data;
				REG_ROWS: rows_q <= cfg_data;
				REG_STEP: step_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (request.cmd == CMD_SEARCH)) begin
			req_q <= request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			hop_q   <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				FSM_IDLE: begin
					if (accept) begin
						if (request.cmd == CMD_WRITE) begin
							done_q          <= 1'b1;
							rsp_q.status    <= STAT_WRITTEN;
							rsp_q.path_cost <= '0;
						end else begin
							state_q <= FSM_CHECK;
						end
					end
				end
				FSM_CHECK: begin
					hop_q <= '0;
					if (reject) begin
						done_q          <= 1'b1;
						rsp_q.status    <= STAT_REJECT;
						rsp_q.path_cost <= '0;
						state_q         <= FSM_IDLE;
					end else begin
						state_q <= FSM_SEARCH;
					end
				end
				FSM_SEARCH: begin
					hop_q <= hop_next;
					if (any_hit) begin
						done_q          <= 1'b1;
						rsp_q.status    <= STAT_FOUND;
						rsp_q.path_cost <= cost;
						state_q         <= FSM_IDLE;
					end else if (!any_new) begin
						// wavefront died out before the target
						done_q          <= 1'b1;
						rsp_q.status    <= STAT_UNREACH;
						rsp_q.path_cost <= '0;
						state_q         <= FSM_IDLE;
					end
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

`ifndef NO_ASSERTIONS
	a_write_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (request.cmd == CMD_WRITE)) |=>
		(done && (result.status == STAT_WRITTEN)))
		else $error("map write not answered in the next cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word shown while still busy");

	a_cost_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != STAT_FOUND)) |-> (result.path_cost == '0))
		else $error("nonzero cost on a result without a path");

	a_search_done: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == FSM_SEARCH && state_q == FSM_IDLE) |->
		(done && (result.status == STAT_FOUND || result.status == STAT_UNREACH)))
		else $error("search ended without a found or unreachable word");
`endif

endmodule

### hdl/hgsp_row_cell.sv
// ----------------------------------------------------------------------------
// hgsp_row_cell
// One grid row: blocked, reached and frontier bits, and one wavefront hop.
// ----------------------------------------------------------------------------
module hgsp_row_cell
	import hgsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  row_ctl_t          row,
	input  logic [GRID_W-1:0] up_frontier,
	input  logic [GRID_W-1:0] dn_frontier,
	output logic [GRID_W-1:0] frontier,
	output row_stat_t         stat
);

	logic [GRID_W-1:0] blk_q;
	logic [GRID_W-1:0] reached_q;
	logic [GRID_W-1:0] frontier_q;
	logic [GRID_W-1:0] vert;
	logic [GRID_W-1:0] nbr;
	logic [GRID_W-1:0] fresh;
	logic [GRID_W-1:0] wr_hot;
	logic [GRID_W-1:0] start_hot;
	logic [GRID_W-1:0] tgt_hot;

	assign wr_hot    = col_onehot(ctl.wr_x);
	assign start_hot = col_onehot(ctl.start_x);
	assign tgt_hot   = col_onehot(ctl.tgt_x);

	// even rows touch columns x-1 and x of the rows around them, odd rows x and x+1
	always_comb begin
		logic [GRID_W-1:0] v;
		v = up_frontier | dn_frontier;
		if (row.odd) begin
			vert = v | {1'b0, v[GRID_W-1:1]};
		end else begin
			vert = v | {v[GRID_W-2:0], 1'b0};
		end
	end

	assign nbr   = vert | {frontier_q[GRID_W-2:0], 1'b0} | {1'b0, frontier_q[GRID_W-1:1]};
	assign fresh = nbr & ~blk_q & ~reached_q & ctl.col_en & {GRID_W{row.row_en}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q      <= '0;
			reached_q  <= '0;
			frontier_q <= '0;
		end else begin
			if (ctl.wr_en && row.wr_sel) begin
				blk_q <= ctl.wr_blk ? (blk_q | wr_hot) : (blk_q & ~wr_hot);
			end
			if (ctl.load) begin
				reached_q  <= row.start_sel ? start_hot : '0;
				frontier_q <= row.start_sel ? start_hot : '0;
			end else if (ctl.step) begin
				reached_q  <= reached_q | fresh;
				frontier_q <= fresh;
			end
		end
	end

	assign frontier     = frontier_q;
	assign stat.hit     = row.tgt_sel && |(fresh & tgt_hot);
	assign stat.any     = |fresh;
	assign stat.tgt_blk = row.tgt_sel && |(blk_q & tgt_hot);

endmodule

### tb/hex_grid_shortest_path_test.sv
// ----------------------------------------------------------------------------
// hex_grid_shortest_path_test
// Self-checking bench for the hex grid shortest path engine: a burst driver
// feeds map writes and searches, a monitor predicts each result word from a
// local breadth-first search over its own copy of the map and compares it.
// ----------------------------------------------------------------------------
module hex_grid_shortest_path_test;
	import hgsp_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE      = 8;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	req_t                 request = '0;
	logic                 done;
	rsp_t                 result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// local copy of the engine state
	logic [CELLS-1:0]  blocked_cells = '0;
	logic [CFG_W-1:0]  cols_cfg = COLS_RESET;
	logic [CFG_W-1:0]  rows_cfg = ROWS_RESET;
	logic [STEP_W-1:0] step_cfg = STEP_RESET;

	req_t request_backlog[$];
	rsp_t expected_results[$];
	rsp_t want;

	bit word_taken = 1'b0;
	int burst_left = 1;
	int gap_left = 0;
	int idle_cycles = 0;
	int errors = 0;
	int words_in = 0;
	int settings_run = 0;
	int n_written = 0;
	int n_found = 0;
	int n_unreach = 0;
	int n_reject = 0;

	hex_grid_shortest_path u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int lim);
		if (v == 0) return 1;
		if (int'(v) > lim) return lim;
		return int'(v);
	endfunction

	// Apply one word to the local map and work out the word the engine answers.
	function automatic rsp_t predict_result(input req_t r);
		rsp_t rsp;
		int w, h, s_idx, t_idx, cur, cx, cy, nx, ny, ddx, ddy, idx;
		int unsigned cost;
		int hop_dist[CELLS];
		int frontier[$];
		rsp = '0;
		if (r.cmd == CMD_WRITE) begin
			blocked_cells[int'(r.cell_y) * GRID_W + int'(r.cell_x)] = r.cell_blocked;
			rsp.status = STAT_WRITTEN;
			return rsp;
		end
		w = clamp_dim(cols_cfg, GRID_W);
		h = clamp_dim(rows_cfg, GRID_H);
		s_idx = int'(r.start_y) * GRID_W + int'(r.start_x);
		t_idx = int'(r.target_y) * GRID_W + int'(r.target_x);
		if (int'(r.start_x) >= w || int'(r.start_y) >= h || int'(r.target_x) >= w ||
				int'(r.target_y) >= h || blocked_cells[t_idx] || s_idx == t_idx) begin
			rsp.status = STAT_REJECT;
			return rsp;
		end
		foreach (hop_dist[i]) hop_dist[i] = -1;
		// the start may be blocked; the wavefront still leaves it
		hop_dist[s_idx] = 0;
		frontier.insert(frontier.size(), s_idx);
		while (frontier.size() != 0 && hop_dist[t_idx] < 0) begin
			cur = frontier.pop_front();
			cx = cur % GRID_W;
			cy = cur / GRID_W;
			for (int n = 0; n < 6; n++) begin
				case (n)
					0: begin ddx = -1; ddy = -1; end
					1: begin ddx = 0;  ddy = -1; end
					2: begin ddx = 1;  ddy = 0;  end
					3: begin ddx = 0;  ddy = 1;  end
					4: begin ddx = -1; ddy = 1;  end
					default: begin ddx = -1; ddy = 0; end
				endcase
				// odd rows sit half a cell right: diagonal steps shift one column
				if ((cy % 2) == 1 && ddy != 0) ddx++;
				nx = cx + ddx;
				ny = cy + ddy;
				if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
				idx = ny * GRID_W + nx;
				if (blocked_cells[idx] || hop_dist[idx] >= 0) continue;
				hop_dist[idx] = hop_dist[cur] + 1;
				frontier.insert(frontier.size(), idx);
			end
		end
		if (hop_dist[t_idx] < 0) begin
			rsp.status = STAT_UNREACH;
		end else begin
			cost = hop_dist[t_idx] * int'(step_cfg);
			if (cost > 32'(COST_MAX)) cost = 32'(COST_MAX);
			rsp.status = STAT_FOUND;
			rsp.path_cost = cost[COST_W-1:0];
		end
		return rsp;
	endfunction

	function automatic req_t raw_word();
		logic [31:0] raw;
		raw = $urandom;
		return raw[$bits(req_t)-1:0];
	endfunction

	function automatic req_t cell_write(input int x, input int y, input bit blk);
		req_t r;
		r = raw_word();
		r.cmd = CMD_WRITE;
		r.cell_x = CRD_W'(x);
		r.cell_y = CRD_W'(y);
		r.cell_blocked = blk;
		return r;
	endfunction

	function automatic req_t path_query(input int sx, input int sy, input int tx, input int ty);
		req_t r;
		r = raw_word();
		r.cmd = CMD_SEARCH;
		r.start_x = CRD_W'(sx);
		r.start_y = CRD_W'(sy);
		r.target_x = CRD_W'(tx);
		r.target_y = CRD_W'(ty);
		return r;
	endfunction

	// Mostly well-formed words inside the used area, some stray ones.
	function automatic req_t random_word(input int density);
		req_t r;
		int w, h, roll;
		r = raw_word();
		w = clamp_dim(cols_cfg, GRID_W);
		h = clamp_dim(rows_cfg, GRID_H);
		roll = $urandom_range(99);
		if (roll < 40) begin
			r.cmd = CMD_WRITE;
			if (roll < 36) begin
				r.cell_x = CRD_W'($urandom_range(w - 1));
				r.cell_y = CRD_W'($urandom_range(h - 1));
			end
			r.cell_blocked = ($urandom_range(99) < density);
		end else begin
			r.cmd = CMD_SEARCH;
			if (roll < 93) begin
				r.start_x = CRD_W'($urandom_range(w - 1));
				r.start_y = CRD_W'($urandom_range(h - 1));
				r.target_x = CRD_W'($urandom_range(w - 1));
				r.target_y = CRD_W'($urandom_range(h - 1));
			end
			if (roll >= 90 && roll < 93) begin
				r.target_x = r.start_x;
				r.target_y = r.start_y;
			end
		end
		return r;
	endfunction

	// Driver: hold a word until taken, then advance or pause for a gap.
	always @(negedge clk) begin
		if (arst_n && (!start || word_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (request_backlog.size() == 0) begin
				start <= 1'b0;
			end else begin
				request <= request_backlog.pop_front();
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = ($urandom_range(7) == 0) ? $urandom_range(30, 80)
						: $urandom_range(1, 20);
					gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// Monitor: predict on every taken word, check every result word.
	always @(posedge clk) begin
		if (arst_n) begin
			word_taken = start && !busy;
			if (word_taken) begin
				expected_results.insert(expected_results.size(), predict_result(request));
				words_in++;
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result word: status %0d cost %0d", $time,
						result.status, result.path_cost);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (result.status !== want.status) begin
						$display("%0t status mismatch: expected %0d actual %0d", $time,
							want.status, result.status);
						errors++;
					end
					if (result.path_cost !== want.path_cost) begin
						$display("%0t path_cost mismatch: expected %0d actual %0d", $time,
							want.path_cost, result.path_cost);
						errors++;
					end
					case (want.status)
						STAT_WRITTEN: n_written++;
						STAT_FOUND:   n_found++;
						STAT_UNREACH: n_unreach++;
						default:      n_reject++;
					endcase
				end
			end
			if (word_taken || done) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic drain();
		while (request_backlog.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_COLS: cols_cfg = data;
			REG_ROWS: rows_cfg = data;
			REG_STEP: step_cfg = data[STEP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic run_setting(input int cols, input int rows, input int step, input int count);
		int density;
		write_reg(REG_COLS, CFG_W'(cols));
		write_reg(REG_ROWS, CFG_W'(rows));
		// bit 4 of the data is not part of the step register
		write_reg(REG_STEP, {1'($urandom), STEP_W'(step)});
		density = $urandom_range(5, 45);
		for (int i = 0; i < count; i++)
			request_backlog.insert(request_backlog.size(), random_word(density));
		settings_run++;
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words at the reset settings
		request_backlog.insert(request_backlog.size(), path_query(0, 0, 15, 15));
		request_backlog.insert(request_backlog.size(), path_query(15, 15, 0, 0));
		request_backlog.insert(request_backlog.size(), path_query(15, 0, 0, 15));
		request_backlog.insert(request_backlog.size(), path_query(3, 3, 3, 3));
		request_backlog.insert(request_backlog.size(), cell_write(15, 15, 1'b1));
		request_backlog.insert(request_backlog.size(), path_query(0, 0, 15, 15));
		request_backlog.insert(request_backlog.size(), cell_write(15, 15, 1'b0));
		// wall off the corner cell
		request_backlog.insert(request_backlog.size(), cell_write(1, 0, 1'b1));
		request_backlog.insert(request_backlog.size(), cell_write(0, 1, 1'b1));
		request_backlog.insert(request_backlog.size(), path_query(7, 8, 0, 0));
		request_backlog.insert(request_backlog.size(), path_query(0, 0, 9, 4));
		request_backlog.insert(request_backlog.size(), path_query(1, 0, 2, 0));
		request_backlog.insert(request_backlog.size(), cell_write(1, 0, 1'b0));
		request_backlog.insert(request_backlog.size(), cell_write(0, 1, 1'b0));
		request_backlog.insert(request_backlog.size(), path_query(4, 5, 5, 6));
		request_backlog.insert(request_backlog.size(), path_query(4, 4, 3, 5));
		request_backlog.insert(request_backlog.size(), path_query(0, 15, 15, 0));
		request_backlog.insert(request_backlog.size(), path_query(15, 14, 0, 1));
		request_backlog.insert(request_backlog.size(), cell_write(0, 0, 1'b1));
		request_backlog.insert(request_backlog.size(), path_query(0, 0, 5, 5));
		request_backlog.insert(request_backlog.size(), cell_write(0, 0, 1'b0));
		request_backlog.insert(request_backlog.size(), cell_write(15, 0, 1'b1));
		request_backlog.insert(request_backlog.size(), cell_write(15, 0, 1'b0));
		settings_run++;
		drain();

		run_setting(16, 16, 1, 200);
		run_setting(16, 16, 15, 200);
		run_setting(1, 1, 4, 40);
		run_setting(0, 0, 0, 40);
		run_setting(31, 31, 0, 150);
		run_setting(4, 3, 7, 150);
		run_setting(2, 16, 2, 150);
		run_setting(16, 2, 5, 150);
		run_setting(8, 8, 15, 150);
		for (int p = 0; p < 4; p++)
			run_setting($urandom_range(31), $urandom_range(31), $urandom_range(15), 120);

		$display("%0d words over %0d register settings", words_in, settings_run);
		$display("%0d map writes, %0d paths found, %0d unreachable, %0d rejected",
			n_written, n_found, n_unreach, n_reject);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
